### hw/rtl/ssil_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set package
// Operation codes and input and output field widths shared by the sorted set files.
// ----------------------------------------------------------------------------
package ssil_pkg;

  localparam int unsigned OUT_WIDTH = 7;
  localparam int unsigned IN_WIDTH  = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

endpackage

### hw/rtl/sorted_set_insert_lookup.sv
// ----------------------------------------------------------------------------
// Sorted set with insert and lookup
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle; all cells compare and shift in parallel.
// The input stalls only while a finished result waits at the output.
// Reset clears the entry count and the output valid; entries stay unwritten.
// ----------------------------------------------------------------------------
module sorted_set_insert_lookup #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            operation,
  input  logic [ssil_pkg::IN_WIDTH-1:0]   value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            found,
  output logic [ssil_pkg::OUT_WIDTH-1:0]  rank,
  output logic [ssil_pkg::OUT_WIDTH-1:0]  count,
  output logic                            overflow
);

  import ssil_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic signed [VALUE_WIDTH-1:0]          key;
  logic [VALUE_WIDTH+IN_WIDTH-1:0]        value_ext;
  logic signed [VALUE_WIDTH-1:0]          entries [CAPACITY];
  logic [CAPACITY-1:0]                    lt;
  logic [CAPACITY-1:0]                    eq;
  logic [CAPACITY-1:0]                    occupied;
  logic                                   hit;
  logic [CW-1:0]                          hit_rank;
  logic [CW-1:0]                          entry_count;
  logic [CW-1:0]                          entry_count_next;
  logic                                   accept;
  logic                                   is_insert;
  logic                                   full;
  logic                                   grow;
  logic                                   drop;
  logic [CW+OUT_WIDTH-1:0]                rank_wide;
  logic [CW+OUT_WIDTH-1:0]                count_wide;

  assign value_ext = {{VALUE_WIDTH{value[IN_WIDTH-1]}}, value};
  assign key       = value_ext[VALUE_WIDTH-1:0];

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign occupied[g] = CW'(g) < entry_count;
      if (g == 0) begin : g_first
        ssil_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
          .clk        (clk),
          .key        (key),
          .prev_entry (key),
          .prev_lt    (1'b1),
          .occupied   (occupied[g]),
          .shift_en   (grow),
          .entry      (entries[g]),
          .lt         (lt[g]),
          .eq         (eq[g])
        );
      end else begin : g_rest
        ssil_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
          .clk        (clk),
          .key        (key),
          .prev_entry (entries[g-1]),
          .prev_lt    (lt[g-1]),
          .occupied   (occupied[g]),
          .shift_en   (grow),
          .entry      (entries[g]),
          .lt         (lt[g]),
          .eq         (eq[g])
        );
      end
    end
  endgenerate

  ssil_rank #(.CAPACITY(CAPACITY)) u_rank (
    .lt    (lt),
    .eq    (eq),
    .found (hit),
    .rank  (hit_rank)
  );

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_insert = (op_t'(operation) == OP_INSERT);
  assign full      = (entry_count == CW'(CAPACITY));
  assign grow      = accept && is_insert && !hit && !full;
  assign drop      = is_insert && !hit && full;

  assign entry_count_next = grow ? entry_count + CW'(1) : entry_count;
  assign rank_wide        = {{OUT_WIDTH{1'b0}}, hit_rank};
  assign count_wide       = {{OUT_WIDTH{1'b0}}, entry_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found    <= hit;
      rank     <= rank_wide[OUT_WIDTH-1:0];
      count    <= count_wide[OUT_WIDTH-1:0];
      overflow <= drop;
    end
  end

endmodule

### hw/rtl/ssil_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one entry, compares it with the broadcast key and takes either the key
// or its lower neighbour's entry when an insert opens a gap at or below it.
// ----------------------------------------------------------------------------
module ssil_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic signed [VALUE_WIDTH-1:0] key,
  input  logic signed [VALUE_WIDTH-1:0] prev_entry,
  input  logic                          prev_lt,
  input  logic                          occupied,
  input  logic                          shift_en,
  output logic signed [VALUE_WIDTH-1:0] entry,
  output logic                          lt,
  output logic                          eq
);

  assign lt = occupied && (entry < key);
  assign eq = occupied && (entry == key);

  always_ff @(posedge clk) begin
    if (shift_en && !lt) begin
      entry <= prev_lt ? key : prev_entry;
    end
  end

endmodule

### hw/rtl/ssil_rank.sv
// ----------------------------------------------------------------------------
// Sorted set rank encoder
// Turns the row of less-than flags, which form a thermometer code, into the
// rank of the key, and merges the equality flags into a presence flag.
// ----------------------------------------------------------------------------
module ssil_rank #(
  parameter int unsigned CAPACITY = 64,
  localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
  input  logic [CAPACITY-1:0] lt,
  input  logic [CAPACITY-1:0] eq,
  output logic                found,
  output logic [CW-1:0]       rank
);

  logic [CAPACITY:0] lt_ext;
  logic [CAPACITY:0] lt_below;
  logic [CAPACITY:0] edge_hit;

  assign lt_ext   = {1'b0, lt};
  assign lt_below = {lt, 1'b1};
  assign edge_hit = lt_below & ~lt_ext;
  assign found    = |eq;

  always_comb begin
    rank = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (edge_hit[i]) begin
        rank = rank | CW'(i);
      end
    end
  end

endmodule

### hw/rtl/ssil_checker.sv
// ----------------------------------------------------------------------------
// Sorted set port checker
// Watches the ports of the sorted set and checks the result fields against
// each other and the output handshake.
// ----------------------------------------------------------------------------
module ssil_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           found,
  input logic [ssil_pkg::OUT_WIDTH-1:0] rank,
  input logic [ssil_pkg::OUT_WIDTH-1:0] count,
  input logic                           overflow
);

  import ssil_pkg::*;

  localparam logic [CAPACITY+OUT_WIDTH-1:0] CAP_WIDE = (CAPACITY + OUT_WIDTH)'(CAPACITY);
  localparam logic [OUT_WIDTH-1:0]          CAP_OUT  = CAP_WIDE[OUT_WIDTH-1:0];

  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_overflow_not_found : assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> !found)
    else $error("overflow reported for a value already present");

  a_overflow_full : assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> count == CAP_OUT)
    else $error("overflow reported while the set is not full");

  a_found_rank : assert property (@(posedge clk) disable iff (rst)
    out_valid && found && CAPACITY < 128 |-> rank < count)
    else $error("present value ranked at or beyond the entry count");

endmodule

bind sorted_set_insert_lookup ssil_checker #(.CAPACITY(CAPACITY)) u_ssil_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .found     (found),
  .rank      (rank),
  .count     (count),
  .overflow  (overflow)
);

### test/sorted_set_insert_lookup_tb.sv
// ----------------------------------------------------------------------------
// Sorted set insert and lookup testbench
// Drives insert and lookup requests into the sorted set and checks every
// result against an in-bench model of the ascending, duplicate-free store.
// Directed requests cover the value extremes and duplicates. Random requests
// run under varying idle and stall rates and include a long output hold-off.
// A final pass fills the store and exercises overflow.
// ----------------------------------------------------------------------------
module sorted_set_insert_lookup_tb;

  import ssil_pkg::*;

  localparam int CAPACITY = 64;

  typedef struct packed {
    logic                 found;
    logic [OUT_WIDTH-1:0] rank;
    logic [OUT_WIDTH-1:0] count;
    logic                 overflow;
  } set_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 operation = OP_LOOKUP;
  logic [IN_WIDTH-1:0]  value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 found;
  logic [OUT_WIDTH-1:0] rank;
  logic [OUT_WIDTH-1:0] count;
  logic                 overflow;

  logic signed [IN_WIDTH-1:0] set_entries [CAPACITY];
  int                         set_size = 0;

  set_result_t         expected_results [$];
  logic [IN_WIDTH-1:0] values_sent [$];

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  sorted_set_insert_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .found     (found),
    .rank      (rank),
    .count     (count),
    .overflow  (overflow)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  function automatic set_result_t predict_set_access(op_t op, logic [IN_WIDTH-1:0] raw);
    set_result_t                r;
    logic signed [IN_WIDTH-1:0] v;
    int                         pos;
    v = raw;
    pos = 0;
    while (pos < set_size && set_entries[pos] < v) pos++;
    r.found = (pos < set_size) && (set_entries[pos] == v);
    r.overflow = 1'b0;
    if (op == OP_INSERT && !r.found) begin
      if (set_size >= CAPACITY) begin
        r.overflow = 1'b1;
      end else begin
        for (int i = set_size; i > pos; i--) set_entries[i] = set_entries[i-1];
        set_entries[pos] = v;
        set_size++;
      end
    end
    r.rank = 7'(pos);
    r.count = 7'(set_size);
    return r;
  endfunction

  function automatic bit set_holds(logic [IN_WIDTH-1:0] raw);
    for (int i = 0; i < set_size; i++) begin
      if (set_entries[i] == $signed(raw)) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_request(op_t op, logic [IN_WIDTH-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_set_access(op, v));
    values_sent.push_back(v);
  endtask

  function automatic logic [IN_WIDTH-1:0] pick_value();
    logic [IN_WIDTH-1:0] v;
    if (values_sent.size() != 0 && $urandom_range(99) < 65) begin
      v = values_sent[$urandom_range(values_sent.size() - 1)];
    end else begin
      case ($urandom_range(3))
        0: v = IN_WIDTH'($signed($urandom_range(16)) - 8);
        1: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3)
                                 : 32'h7fff_ffff - $urandom_range(3);
        default: v = $urandom;
      endcase
    end
    return v;
  endfunction

  task automatic send_random_request();
    op_t op;
    op = ($urandom_range(99) < 55) ? OP_INSERT : OP_LOOKUP;
    send_request(op, pick_value());
  endtask

  task automatic test_directed();
    send_request(OP_LOOKUP, 32'h0000_0000);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_INSERT, 32'h7fff_ffff);
    send_request(OP_INSERT, 32'hffff_ffff);
    send_request(OP_INSERT, 32'h0000_0001);
    send_request(OP_INSERT, 32'h0000_0000);
    send_request(OP_INSERT, 32'h7fff_ffff);
    send_request(OP_INSERT, 32'h8000_0000);
    send_request(OP_LOOKUP, 32'h8000_0000);
    send_request(OP_LOOKUP, 32'h7fff_ffff);
    send_request(OP_LOOKUP, 32'hffff_ffff);
    send_request(OP_LOOKUP, 32'h0000_0005);
    send_request(OP_LOOKUP, 32'hffff_fffb);
    send_request(OP_LOOKUP, 32'h8000_0001);
    send_request(OP_INSERT, 32'h5555_5555);
    send_request(OP_INSERT, 32'haaaa_aaaa);
    send_request(OP_LOOKUP, 32'haaaa_aaaa);
    send_request(OP_LOOKUP, 32'h7fff_fffe);
  endtask

  task automatic test_random(int items, int sender_idle, int receiver_stall);
    send_idle_pct  = sender_idle;
    recv_stall_pct = receiver_stall;
    repeat (items) send_random_request();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    repeat (20) send_random_request();
  endtask

  task automatic test_full_store();
    logic [IN_WIDTH-1:0] fill_value;
    logic [IN_WIDTH-1:0] absent_value;
    send_idle_pct  = 12;
    recv_stall_pct = 30;
    fill_value = 32'h0123_4567;
    while (set_size < CAPACITY) begin
      send_request(OP_INSERT, fill_value);
      fill_value = fill_value + 32'h0400_0001;
    end
    do absent_value = $urandom; while (set_holds(absent_value));
    send_request(OP_INSERT, absent_value);
    send_request(OP_INSERT, set_entries[0]);
    send_request(OP_INSERT, set_entries[CAPACITY-1]);
    send_request(OP_LOOKUP, absent_value);
    send_request(OP_LOOKUP, set_entries[CAPACITY/2]);
    repeat (40) send_random_request();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    set_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (error_count < 10) begin
          $display("unexpected result: found=%0d rank=%0d count=%0d overflow=%0d",
                   found, rank, count, overflow);
        end
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (found !== exp_r.found || rank !== exp_r.rank ||
            count !== exp_r.count || overflow !== exp_r.overflow) begin
          if (error_count < 10) begin
            $display("mismatch: expected found=%0d rank=%0d count=%0d overflow=%0d",
                     exp_r.found, exp_r.rank, exp_r.count, exp_r.overflow);
            $display("          actual   found=%0d rank=%0d count=%0d overflow=%0d",
                     found, rank, count, overflow);
          end
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct  = 12;
    recv_stall_pct = 65;
    test_directed();
    test_random(150, 12, 65);
    test_backpressure();
    test_random(150, 65, 12);
    test_random(150, 0, 0);
    test_full_store();
    in_valid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ssil_pkg.sv
hw/rtl/ssil_cell.sv
hw/rtl/ssil_rank.sv
hw/rtl/sorted_set_insert_lookup.sv
hw/rtl/ssil_checker.sv
test/sorted_set_insert_lookup_tb.sv
